@@ hw/rtl/avm_pkg.sv @@
`timescale 1ns / 1ps

package avm_pkg;

  localparam int unsigned MemDepthDefault = 256;

  typedef enum logic [1:0] {
    REQ_EXEC   = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_CLEAR    = 5'd0,
    OP_AT       = 5'd1,
    OP_SET      = 5'd2,
    OP_INSERT   = 5'd3,
    OP_ERASE    = 5'd4,
    OP_ADDCONST = 5'd5,
    OP_SUBCONST = 5'd6,
    OP_MULCONST = 5'd7,
    OP_DIVCONST = 5'd8,
    OP_ADDMEM   = 5'd9,
    OP_SUBMEM   = 5'd10,
    OP_MULMEM   = 5'd11,
    OP_DIVMEM   = 5'd12,
    OP_JUMPREL  = 5'd13,
    OP_JUMPZERO = 5'd14,
    OP_JUMPNZ   = 5'd15,
    OP_NOOP     = 5'd16,
    OP_HALT     = 5'd17,
    OP_OUTPUT   = 5'd18,
    OP_CHECKMEM = 5'd19
  } op_e;

endpackage

@@ hw/rtl/accumulator_vm_execute_unit.sv @@
`timescale 1ns / 1ps

// Execute unit of an accumulator machine with a variable-length data store.
// An item is accepted at a rising edge where start is high and busy is low.
// Its kind picks execute, append word, read word or clear all. Each item gives
// exactly one result, shown for one cycle while done_o is high; the receiver
// cannot hold it off, and a new item may be accepted in that same cycle.
// A simple item passes through the decode state and then the registered
// result strobe. Multiply and divide run on one shared 65-bit adder at one
// bit per cycle. Insert and erase move each word with a read state and a
// write state, through a data memory with one read and one write port;
// insert ends with a state that writes the new word. Reset clears the
// accumulator, the word count and the status; memory contents are not
// cleared, as entries above the count are never read.
// Halted and errored states are sticky until a clear item arrives.

module accumulator_vm_execute_unit #(
  parameter int unsigned MEM_DEPTH = avm_pkg::MemDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [4:0]         instr_opcode_i,
  input  logic signed [63:0] instr_argument_i,
  input  logic signed [63:0] load_word_i,
  input  logic [7:0]         read_index_i,
  output logic               done_o,
  output logic signed [63:0] accumulator_o,
  output logic signed [63:0] pc_step_o,
  output logic [1:0]         run_status_o,
  output logic               show_accumulator_o,
  output logic signed [63:0] read_data_o,
  output logic [8:0]         word_count_o
);

  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned SW = $clog2(MEM_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_DIV_FIN,
    S_INS_RD, S_INS_WR, S_INS_FIN, S_ERS_RD, S_ERS_WR
  } state_e;

  state_e              state_q, state_d;
  avm_pkg::req_e       req_q, req_d;
  avm_pkg::status_e    st_q, st_d;
  logic [4:0]          op_q, op_d;
  logic [63:0]         arg_q, arg_d, load_q, load_d;
  logic [7:0]          ridx_q, ridx_d;
  logic [63:0]         acc_q, acc_d;
  logic [SW-1:0]       size_q, size_d, ptr_q, ptr_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [63:0]         x_q, x_d, y_q, y_d, p_q, p_d;
  logic                neg_q, neg_d;
  logic [63:0]         pc_q, pc_d, rd_q, rd_d;
  logic                show_q, show_d, done_q, done_d;

  logic [63:0]         mem [MEM_DEPTH];
  logic [63:0]         mem_rdata_q;
  logic [AW-1:0]       mem_raddr, mem_waddr;
  logic [63:0]         mem_wdata;
  logic                mem_we;

  logic [64:0]         alu_a, alu_b;
  logic                alu_sub;
  logic [65:0]         alu_res;

  logic                idx_ok;
  logic [63:0]         div_n, div_d;
  logic [64:0]         rem_shift;
  logic                q_bit, taken;

  assign alu_res = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b}) + 66'(alu_sub);

  assign idx_ok    = arg_q < 64'(size_q);
  assign rem_shift = {p_q, x_q[63]};
  assign q_bit     = ~alu_res[65];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    st_d      = st_q;
    op_d      = op_q;
    arg_d     = arg_q;
    load_d    = load_q;
    ridx_d    = ridx_q;
    acc_d     = acc_q;
    size_d    = size_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    p_d       = p_q;
    neg_d     = neg_q;
    pc_d      = pc_q;
    rd_d      = rd_q;
    show_d    = show_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(ptr_q);
    mem_wdata = mem_rdata_q;
    mem_raddr = AW'(ptr_q);
    alu_a     = 65'(acc_q);
    alu_b     = 65'(arg_q);
    alu_sub   = 1'b0;
    div_n     = acc_q;
    div_d     = arg_q;
    taken     = 1'b0;

    case (state_q)
      S_IDLE: begin
        mem_raddr = (req_type_i == avm_pkg::REQ_READ) ? AW'(read_index_i)
                                                      : AW'(instr_argument_i);
        if (start) begin
          req_d   = avm_pkg::req_e'(req_type_i);
          op_d    = instr_opcode_i;
          arg_d   = instr_argument_i;
          load_d  = load_word_i;
          ridx_d  = read_index_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        pc_d    = '0;
        show_d  = 1'b0;
        rd_d    = '0;
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (req_q)
          avm_pkg::REQ_CLEAR: begin
            acc_d  = '0;
            size_d = '0;
            st_d   = avm_pkg::ST_RUN;
          end
          avm_pkg::REQ_APPEND: begin
            if (size_q < SW'(MEM_DEPTH)) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(size_q);
              mem_wdata = load_q;
              size_d    = size_q + SW'(1);
            end
          end
          avm_pkg::REQ_READ: begin
            if (64'(ridx_q) < 64'(size_q)) begin
              rd_d = mem_rdata_q;
            end
          end
          default: begin
            if (st_q == avm_pkg::ST_RUN) begin
              pc_d = 64'd1;
              case (avm_pkg::op_e'(op_q))
                avm_pkg::OP_CLEAR: acc_d = '0;
                avm_pkg::OP_AT: begin
                  if (idx_ok) begin
                    acc_d = mem_rdata_q;
                  end else begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end
                end
                avm_pkg::OP_SET: begin
                  if (idx_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(arg_q);
                    mem_wdata = acc_q;
                  end else begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end
                end
                avm_pkg::OP_INSERT: begin
                  if (arg_q > 64'(size_q) || size_q >= SW'(MEM_DEPTH)) begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end else if (arg_q == 64'(size_q)) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(arg_q);
                    mem_wdata = acc_q;
                    size_d    = size_q + SW'(1);
                  end else begin
                    ptr_d   = size_q;
                    state_d = S_INS_RD;
                    done_d  = 1'b0;
                  end
                end
                avm_pkg::OP_ERASE: begin
                  if (!idx_ok) begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end else begin
                    ptr_d = SW'(arg_q);
                    if ((SW + 1)'(SW'(arg_q)) + (SW + 1)'(1) < (SW + 1)'(size_q)) begin
                      state_d = S_ERS_RD;
                      done_d  = 1'b0;
                    end else begin
                      size_d = size_q - SW'(1);
                    end
                  end
                end
                avm_pkg::OP_ADDCONST, avm_pkg::OP_SUBCONST: begin
                  alu_sub = (avm_pkg::op_e'(op_q) == avm_pkg::OP_SUBCONST);
                  acc_d   = alu_res[63:0];
                end
                avm_pkg::OP_MULCONST: begin
                  x_d     = acc_q;
                  y_d     = arg_q;
                  p_d     = '0;
                  cnt_d   = '0;
                  state_d = S_MUL;
                  done_d  = 1'b0;
                end
                avm_pkg::OP_DIVCONST: begin
                  if (arg_q == '0) begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end else begin
                    neg_d   = acc_q[63] ^ div_d[63];
                    x_d     = acc_q[63] ? (64'd0 - acc_q) : acc_q;
                    y_d     = div_d[63] ? (64'd0 - div_d) : div_d;
                    p_d     = '0;
                    cnt_d   = '0;
                    state_d = S_DIV;
                    done_d  = 1'b0;
                  end
                end
                avm_pkg::OP_ADDMEM, avm_pkg::OP_SUBMEM,
                avm_pkg::OP_MULMEM, avm_pkg::OP_DIVMEM: begin
                  div_d = mem_rdata_q;
                  alu_b = 65'(mem_rdata_q);
                  if (!idx_ok) begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end else if (avm_pkg::op_e'(op_q) == avm_pkg::OP_ADDMEM ||
                               avm_pkg::op_e'(op_q) == avm_pkg::OP_SUBMEM) begin
                    alu_sub = (avm_pkg::op_e'(op_q) == avm_pkg::OP_SUBMEM);
                    acc_d   = alu_res[63:0];
                  end else if (avm_pkg::op_e'(op_q) == avm_pkg::OP_MULMEM) begin
                    x_d     = acc_q;
                    y_d     = mem_rdata_q;
                    p_d     = '0;
                    cnt_d   = '0;
                    state_d = S_MUL;
                    done_d  = 1'b0;
                  end else if (mem_rdata_q == '0) begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end else begin
                    neg_d   = acc_q[63] ^ div_d[63];
                    x_d     = acc_q[63] ? (64'd0 - acc_q) : acc_q;
                    y_d     = div_d[63] ? (64'd0 - div_d) : div_d;
                    p_d     = '0;
                    cnt_d   = '0;
                    state_d = S_DIV;
                    done_d  = 1'b0;
                  end
                end
                avm_pkg::OP_JUMPREL, avm_pkg::OP_JUMPZERO, avm_pkg::OP_JUMPNZ: begin
                  taken = (avm_pkg::op_e'(op_q) == avm_pkg::OP_JUMPREL) ||
                          (avm_pkg::op_e'(op_q) == avm_pkg::OP_JUMPZERO && acc_q == '0) ||
                          (avm_pkg::op_e'(op_q) == avm_pkg::OP_JUMPNZ && acc_q != '0);
                  if (taken) begin
                    if (arg_q != '0) begin
                      pc_d = arg_q;
                    end else begin
                      st_d = avm_pkg::ST_ERR;
                    end
                  end
                end
                avm_pkg::OP_NOOP: pc_d = 64'd1;
                avm_pkg::OP_HALT: begin
                  st_d = avm_pkg::ST_HALT;
                  pc_d = '0;
                end
                avm_pkg::OP_OUTPUT: show_d = 1'b1;
                avm_pkg::OP_CHECKMEM: begin
                  if (64'(size_q) < arg_q) begin
                    st_d = avm_pkg::ST_ERR;
                    pc_d = '0;
                  end
                end
                default: begin
                  st_d = avm_pkg::ST_ERR;
                  pc_d = '0;
                end
              endcase
            end
          end
        endcase
      end
      S_MUL: begin
        alu_a = 65'(p_q);
        alu_b = 65'(x_q);
        if (y_q[0]) begin
          p_d = alu_res[63:0];
        end
        x_d   = {x_q[62:0], 1'b0};
        y_d   = {1'b0, y_q[63:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          acc_d   = y_q[0] ? alu_res[63:0] : p_q;
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_DIV: begin
        alu_a   = rem_shift;
        alu_b   = 65'(y_q);
        alu_sub = 1'b1;
        p_d     = q_bit ? alu_res[63:0] : rem_shift[63:0];
        x_d     = {x_q[62:0], q_bit};
        cnt_d   = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_DIV_FIN;
        end
      end
      S_DIV_FIN: begin
        alu_a   = '0;
        alu_b   = 65'(x_q);
        alu_sub = neg_q;
        acc_d   = alu_res[63:0];
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      S_INS_RD: begin
        mem_raddr = AW'(ptr_q - SW'(1));
        state_d   = S_INS_WR;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_q);
        mem_wdata = mem_rdata_q;
        ptr_d     = ptr_q - SW'(1);
        if (ptr_q - SW'(1) > SW'(arg_q)) begin
          state_d = S_INS_RD;
        end else begin
          state_d = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(arg_q);
        mem_wdata = acc_q;
        size_d    = size_q + SW'(1);
        state_d   = S_IDLE;
        done_d    = 1'b1;
      end
      S_ERS_RD: begin
        mem_raddr = AW'(ptr_q + SW'(1));
        state_d   = S_ERS_WR;
      end
      S_ERS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_q);
        mem_wdata = mem_rdata_q;
        ptr_d     = ptr_q + SW'(1);
        if ((SW + 1)'(ptr_q) + (SW + 1)'(2) < (SW + 1)'(size_q)) begin
          state_d = S_ERS_RD;
        end else begin
          size_d  = size_q - SW'(1);
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= avm_pkg::ST_RUN;
      acc_q   <= '0;
      size_q  <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      acc_q   <= acc_d;
      size_q  <= size_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    op_q   <= op_d;
    arg_q  <= arg_d;
    load_q <= load_d;
    ridx_q <= ridx_d;
    x_q    <= x_d;
    y_q    <= y_d;
    p_q    <= p_d;
    neg_q  <= neg_d;
    pc_q   <= pc_d;
    rd_q   <= rd_d;
    show_q <= show_d;
  end

  assign busy               = (state_q != S_IDLE);
  assign done_o             = done_q;
  assign accumulator_o      = $signed(acc_q);
  assign pc_step_o          = $signed(pc_q);
  assign run_status_o       = st_q;
  assign show_accumulator_o = show_q;
  assign read_data_o        = $signed(rd_q);
  assign word_count_o       = 9'(size_q);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("Result strobe while busy.");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SW'(MEM_DEPTH)) else $error("Word count beyond memory depth.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("Accepted item did not start work.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_status_o != 2'd3) else $error("Invalid run status.");

  a_size_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !done_d) |=> $stable(size_q) || done_o)
    else $error("Word count changed in the middle of an item.");

endmodule
